// ===== rtl/cpu_bus_cycle_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the CPU bus cycle sequencer
// Each macro places one labeled concurrent assertion that is clocked on the
// rising edge and disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef CPU_BUS_CYCLE_SEQUENCER_ASSERT_SVH
`define CPU_BUS_CYCLE_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBCS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bus cycle sequencer check failed");

// The consequent must hold in the cycle after the antecedent.
`define CBCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bus cycle sequencer check failed");

`endif

// ===== rtl/cbcs_pkg.sv =====
// ----------------------------------------------------------------------------
// CPU bus cycle sequencer package
// Shared widths, codes, phase encoding and beat structures.
// ----------------------------------------------------------------------------
package cbcs_pkg;

    localparam int ADDR_W = 24;
    localparam int DATA_W = 16;
    localparam int BYTE_W = 8;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_RMW   = 2'd3
    } cmd_t;

    localparam logic [1:0] SPACE_DATA = 2'd0;
    localparam logic [1:0] SPACE_PROG = 2'd1;

    localparam logic [2:0] MEM_NONE    = 3'd0;
    localparam logic [2:0] MEM_RD_BYTE = 3'd1;
    localparam logic [2:0] MEM_RD_WORD = 3'd2;
    localparam logic [2:0] MEM_WR_BYTE = 3'd3;
    localparam logic [2:0] MEM_WR_WORD = 3'd4;

    localparam logic [2:0] STATUS_NONE     = 3'd0;
    localparam logic [2:0] STATUS_DONE     = 3'd1;
    localparam logic [2:0] STATUS_ADDR_ERR = 3'd2;

    localparam int PH_COUNT = 23;

    typedef enum logic [PH_COUNT-1:0] {
        PH_IDLE   = 23'd1 << 0,
        PH_R0     = 23'd1 << 1,
        PH_R1     = 23'd1 << 2,
        PH_R2     = 23'd1 << 3,
        PH_RWAIT  = 23'd1 << 4,
        PH_R3     = 23'd1 << 5,
        PH_W0     = 23'd1 << 6,
        PH_W1     = 23'd1 << 7,
        PH_W2     = 23'd1 << 8,
        PH_WWAIT  = 23'd1 << 9,
        PH_W3     = 23'd1 << 10,
        PH_MR0    = 23'd1 << 11,
        PH_MR1    = 23'd1 << 12,
        PH_MR2    = 23'd1 << 13,
        PH_MRWAIT = 23'd1 << 14,
        PH_MR3    = 23'd1 << 15,
        PH_MOD0   = 23'd1 << 16,
        PH_MOD1   = 23'd1 << 17,
        PH_MW0    = 23'd1 << 18,
        PH_MW1    = 23'd1 << 19,
        PH_MW2    = 23'd1 << 20,
        PH_MWWAIT = 23'd1 << 21,
        PH_MW3    = 23'd1 << 22
    } phase_t;

    typedef struct packed {
        cmd_t              command;
        logic [ADDR_W-1:0] addr;
        logic              byte_op;
        logic [1:0]        space;
        logic              supervisor;
        logic [DATA_W-1:0] write_data;
        logic [BYTE_W-1:0] modified_byte;
        logic              bus_request;
        logic              mem_idle;
        logic [DATA_W-1:0] mem_read_data;
    } in_item_t;

    typedef struct packed {
        logic              addr_strobe;
        logic              upper_strobe;
        logic              lower_strobe;
        logic              read_not_write;
        logic              data_ack;
        logic [2:0]        func_code;
        logic [ADDR_W-1:0] bus_addr;
        logic [DATA_W-1:0] bus_data;
        logic              bus_grant;
        logic [2:0]        mem_op;
        logic [DATA_W-1:0] mem_write_data;
        logic [2:0]        status;
    } out_item_t;

endpackage

// ===== rtl/cpu_bus_cycle_sequencer.sv =====
// ----------------------------------------------------------------------------
// CPU bus cycle sequencer
// Steps read, write and read-modify-write bus cycles of a 16-bit CPU bus,
// one bus clock tick per input beat.
// ----------------------------------------------------------------------------
// Each input beat carries one bus clock tick: the command, the access fields
// and the sampled bus_request, mem_idle and mem_read_data levels. Each input
// beat yields exactly one output beat with the bus levels after that tick,
// the memory start code, the write data and the status.
// An input beat is captured in the input register and then processed into the
// output register, where its output beat becomes valid and can be taken by
// the receiver.
// A new beat is accepted every cycle as long as the receiver keeps taking
// output beats.
// Reset clears the phase to idle, drops all strobes and the grant, and
// zeroes the held address, data and function codes.
// When the receiver stalls, the output register holds its beat, the input
// register fills, and in_ready drops until the output beat is taken.
// ----------------------------------------------------------------------------
module cpu_bus_cycle_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    command,
    input  logic [cbcs_pkg::ADDR_W-1:0]   addr,
    input  logic                          byte_op,
    input  logic [1:0]                    space,
    input  logic                          supervisor,
    input  logic [cbcs_pkg::DATA_W-1:0]   write_data,
    input  logic [cbcs_pkg::BYTE_W-1:0]   modified_byte,
    input  logic                          bus_request,
    input  logic                          mem_idle,
    input  logic [cbcs_pkg::DATA_W-1:0]   mem_read_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          addr_strobe,
    output logic                          upper_strobe,
    output logic                          lower_strobe,
    output logic                          read_not_write,
    output logic                          data_ack,
    output logic [2:0]                    func_code,
    output logic [cbcs_pkg::ADDR_W-1:0]   bus_addr,
    output logic [cbcs_pkg::DATA_W-1:0]   bus_data,
    output logic                          bus_grant,
    output logic [2:0]                    mem_op,
    output logic [cbcs_pkg::DATA_W-1:0]   mem_write_data,
    output logic [2:0]                    status
);

    cbcs_pkg::in_item_t  up_item;
    cbcs_pkg::in_item_t  core_item;
    cbcs_pkg::out_item_t res;
    logic                core_valid;
    logic                core_ready;

    always_comb
    begin
        up_item.command       = cbcs_pkg::cmd_t'(command);
        up_item.addr          = addr;
        up_item.byte_op       = byte_op;
        up_item.space         = space;
        up_item.supervisor    = supervisor;
        up_item.write_data    = write_data;
        up_item.modified_byte = modified_byte;
        up_item.bus_request   = bus_request;
        up_item.mem_idle      = mem_idle;
        up_item.mem_read_data = mem_read_data;
    end

    cbcs_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .up_item  (up_item),
        .dn_valid (core_valid),
        .dn_ready (core_ready),
        .dn_item  (core_item)
    );

    cbcs_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (core_valid),
        .item_ready (core_ready),
        .item       (core_item),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res        (res)
    );

    assign addr_strobe    = res.addr_strobe;
    assign upper_strobe   = res.upper_strobe;
    assign lower_strobe   = res.lower_strobe;
    assign read_not_write = res.read_not_write;
    assign data_ack       = res.data_ack;
    assign func_code      = res.func_code;
    assign bus_addr       = res.bus_addr;
    assign bus_data       = res.bus_data;
    assign bus_grant      = res.bus_grant;
    assign mem_op         = res.mem_op;
    assign mem_write_data = res.mem_write_data;
    assign status         = res.status;

endmodule

// ===== rtl/cbcs_in_stage.sv =====
// ----------------------------------------------------------------------------
// Input register stage
// Captures one input beat per cycle while the core takes beats, and presents it to the sequencer core.
// ----------------------------------------------------------------------------
module cbcs_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  cbcs_pkg::in_item_t up_item,
    output logic               dn_valid,
    input  logic               dn_ready,
    output cbcs_pkg::in_item_t dn_item
);

    logic               valid_reg;
    cbcs_pkg::in_item_t item_reg;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            item_reg <= up_item;
        end
    end

endmodule

// ===== rtl/cbcs_core.sv =====
// ----------------------------------------------------------------------------
// Sequencer core
// Holds the bus cycle state, advances it by one tick per input beat and
// registers the resulting bus levels in the output register.
// ----------------------------------------------------------------------------
`include "cpu_bus_cycle_sequencer_assert.svh"

module cbcs_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  cbcs_pkg::in_item_t  item,
    output logic                res_valid,
    input  logic                res_ready,
    output cbcs_pkg::out_item_t res
);

    function automatic logic [cbcs_pkg::DATA_W-1:0] place_data(
        input logic [cbcs_pkg::DATA_W-1:0] v,
        input logic                        byte_op,
        input logic                        odd,
        input logic [cbcs_pkg::DATA_W-1:0] cur
    );
        logic [cbcs_pkg::DATA_W-1:0] r;
        r = v;
        if (byte_op)
        begin
            if (!odd)
            begin
                r = {v[7:0], cur[7:0]};
            end
            else
            begin
                r = {cur[15:8], v[7:0]};
            end
        end
        return r;
    endfunction

    cbcs_pkg::phase_t              phase_reg, phase_next, cur;
    logic [cbcs_pkg::ADDR_W-1:0]   held_addr_reg, held_addr_next;
    logic                          held_byte_reg, held_byte_next;
    logic [1:0]                    held_space_reg, held_space_next;
    logic [cbcs_pkg::DATA_W-1:0]   held_wdata_reg, held_wdata_next;
    logic                          as_reg, as_next;
    logic                          uds_reg, uds_next;
    logic                          lds_reg, lds_next;
    logic                          rw_reg, rw_next;
    logic                          dtack_reg, dtack_next;
    logic [2:0]                    fc_reg, fc_next;
    logic [cbcs_pkg::ADDR_W-1:0]   drv_addr_reg, drv_addr_next;
    logic [cbcs_pkg::DATA_W-1:0]   drv_data_reg, drv_data_next;
    logic                          grant_reg, grant_next;
    logic [2:0]                    tick_mem_op;
    logic [cbcs_pkg::DATA_W-1:0]   tick_wdata;
    logic [2:0]                    tick_status;
    logic                          is_read;
    logic                          step;
    logic                          res_valid_reg;
    cbcs_pkg::out_item_t           res_reg, res_next;

    assign item_ready = !res_valid_reg || res_ready;
    assign step       = item_valid && item_ready;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    always_comb
    begin
        held_addr_next  = held_addr_reg;
        held_byte_next  = held_byte_reg;
        held_space_next = held_space_reg;
        held_wdata_next = held_wdata_reg;
        as_next         = as_reg;
        uds_next        = uds_reg;
        lds_next        = lds_reg;
        rw_next         = rw_reg;
        dtack_next      = dtack_reg;
        fc_next         = fc_reg;
        drv_addr_next   = drv_addr_reg;
        drv_data_next   = drv_data_reg;
        grant_next      = grant_reg;
        tick_mem_op     = cbcs_pkg::MEM_NONE;
        tick_wdata      = '0;
        tick_status     = cbcs_pkg::STATUS_NONE;
        is_read         = 1'b0;
        cur             = phase_reg;

        if (phase_reg == cbcs_pkg::PH_IDLE && item.command != cbcs_pkg::CMD_NONE)
        begin
            held_addr_next  = item.addr;
            held_byte_next  = item.byte_op;
            held_space_next = item.space;
            held_wdata_next = item.write_data;
            unique case (item.command)
                cbcs_pkg::CMD_READ:  cur = cbcs_pkg::PH_R0;
                cbcs_pkg::CMD_WRITE: cur = cbcs_pkg::PH_W0;
                default:             cur = cbcs_pkg::PH_MR0;
            endcase
        end

        phase_next = cur;

        if (grant_reg)
        begin
            if (!item.bus_request)
            begin
                grant_next = 1'b0;
            end
        end
        else
        begin
            unique case (cur)
                cbcs_pkg::PH_IDLE:
                begin
                    if (item.bus_request)
                    begin
                        grant_next = 1'b1;
                    end
                end
                cbcs_pkg::PH_R0, cbcs_pkg::PH_MR0, cbcs_pkg::PH_W0, cbcs_pkg::PH_MW0:
                begin
                    is_read = (cur == cbcs_pkg::PH_R0) || (cur == cbcs_pkg::PH_MR0);
                    if (!held_byte_next && held_addr_next[0])
                    begin
                        tick_status = cbcs_pkg::STATUS_ADDR_ERR
                            + {1'b0, held_space_next == cbcs_pkg::SPACE_PROG, 1'b0}
                            + {2'b00, is_read};
                        phase_next  = cbcs_pkg::PH_IDLE;
                        as_next     = 1'b0;
                        uds_next    = 1'b0;
                        lds_next    = 1'b0;
                        dtack_next  = 1'b0;
                        fc_next     = '0;
                    end
                    else
                    begin
                        fc_next       = {item.supervisor,
                                         held_space_next == cbcs_pkg::SPACE_PROG,
                                         held_space_next == cbcs_pkg::SPACE_DATA};
                        rw_next       = 1'b1;
                        drv_addr_next = held_addr_next;
                    end
                end
                cbcs_pkg::PH_R1, cbcs_pkg::PH_MR1:
                begin
                    as_next  = 1'b1;
                    uds_next = !held_byte_next || !held_addr_next[0];
                    lds_next = !held_byte_next || held_addr_next[0];
                end
                cbcs_pkg::PH_R2, cbcs_pkg::PH_MR2, cbcs_pkg::PH_RWAIT, cbcs_pkg::PH_MRWAIT:
                begin
                    if (cur == cbcs_pkg::PH_R2 || cur == cbcs_pkg::PH_MR2)
                    begin
                        tick_mem_op = held_byte_next ? cbcs_pkg::MEM_RD_BYTE
                                                     : cbcs_pkg::MEM_RD_WORD;
                        phase_next  = (cur == cbcs_pkg::PH_R2) ? cbcs_pkg::PH_RWAIT
                                                               : cbcs_pkg::PH_MRWAIT;
                    end
                    if (item.mem_idle)
                    begin
                        drv_data_next = place_data(
                            held_byte_next ? {8'h00, item.mem_read_data[7:0]}
                                           : item.mem_read_data,
                            held_byte_next, held_addr_next[0], drv_data_reg);
                        dtack_next    = 1'b1;
                    end
                end
                cbcs_pkg::PH_R3:
                begin
                    as_next     = 1'b0;
                    uds_next    = 1'b0;
                    lds_next    = 1'b0;
                    dtack_next  = 1'b0;
                    fc_next     = '0;
                    phase_next  = cbcs_pkg::PH_IDLE;
                    tick_status = cbcs_pkg::STATUS_DONE;
                end
                cbcs_pkg::PH_MR3:
                begin
                    as_next    = 1'b1;
                    uds_next   = 1'b0;
                    lds_next   = 1'b0;
                    dtack_next = 1'b0;
                    fc_next    = '0;
                end
                cbcs_pkg::PH_MOD0:
                begin
                    phase_next = cur;
                end
                cbcs_pkg::PH_MOD1:
                begin
                    held_wdata_next = {8'h00, item.modified_byte};
                end
                cbcs_pkg::PH_W1, cbcs_pkg::PH_MW1:
                begin
                    as_next       = 1'b1;
                    rw_next       = 1'b0;
                    drv_data_next = place_data(held_wdata_next, held_byte_next,
                                               held_addr_next[0], drv_data_reg);
                end
                cbcs_pkg::PH_W2, cbcs_pkg::PH_MW2, cbcs_pkg::PH_WWAIT, cbcs_pkg::PH_MWWAIT:
                begin
                    if (cur == cbcs_pkg::PH_W2 || cur == cbcs_pkg::PH_MW2)
                    begin
                        uds_next   = uds_reg || !held_byte_next || !held_addr_next[0];
                        lds_next   = lds_reg || !held_byte_next || held_addr_next[0];
                        if (held_byte_next)
                        begin
                            tick_mem_op = cbcs_pkg::MEM_WR_BYTE;
                            tick_wdata  = {8'h00, held_wdata_next[7:0]};
                        end
                        else
                        begin
                            tick_mem_op = cbcs_pkg::MEM_WR_WORD;
                            tick_wdata  = held_wdata_next;
                        end
                        phase_next = (cur == cbcs_pkg::PH_W2) ? cbcs_pkg::PH_WWAIT
                                                              : cbcs_pkg::PH_MWWAIT;
                    end
                    if (item.mem_idle)
                    begin
                        dtack_next = 1'b1;
                    end
                end
                default:
                begin
                    as_next     = 1'b0;
                    uds_next    = 1'b0;
                    lds_next    = 1'b0;
                    dtack_next  = 1'b0;
                    fc_next     = '0;
                    rw_next     = 1'b1;
                    phase_next  = cbcs_pkg::PH_IDLE;
                    tick_status = cbcs_pkg::STATUS_DONE;
                end
            endcase

            if (phase_next != cbcs_pkg::PH_IDLE)
            begin
                if ((phase_next != cbcs_pkg::PH_RWAIT && phase_next != cbcs_pkg::PH_WWAIT
                     && phase_next != cbcs_pkg::PH_MRWAIT
                     && phase_next != cbcs_pkg::PH_MWWAIT) || item.mem_idle)
                begin
                    phase_next = cbcs_pkg::phase_t'({phase_next[cbcs_pkg::PH_COUNT-2:0],
                                                     1'b0});
                end
            end
        end

        res_next.addr_strobe    = as_next;
        res_next.upper_strobe   = uds_next;
        res_next.lower_strobe   = lds_next;
        res_next.read_not_write = rw_next;
        res_next.data_ack       = dtack_next;
        res_next.func_code      = fc_next;
        res_next.bus_addr       = drv_addr_next;
        res_next.bus_data       = drv_data_next;
        res_next.bus_grant      = grant_next;
        res_next.mem_op         = tick_mem_op;
        res_next.mem_write_data = tick_wdata;
        res_next.status         = tick_status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= cbcs_pkg::PH_IDLE;
            held_addr_reg  <= '0;
            held_byte_reg  <= 1'b0;
            held_space_reg <= '0;
            held_wdata_reg <= '0;
            as_reg         <= 1'b0;
            uds_reg        <= 1'b0;
            lds_reg        <= 1'b0;
            rw_reg         <= 1'b0;
            dtack_reg      <= 1'b0;
            fc_reg         <= '0;
            drv_addr_reg   <= '0;
            drv_data_reg   <= '0;
            grant_reg      <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg      <= phase_next;
                held_addr_reg  <= held_addr_next;
                held_byte_reg  <= held_byte_next;
                held_space_reg <= held_space_next;
                held_wdata_reg <= held_wdata_next;
                as_reg         <= as_next;
                uds_reg        <= uds_next;
                lds_reg        <= lds_next;
                rw_reg         <= rw_next;
                dtack_reg      <= dtack_next;
                fc_reg         <= fc_next;
                drv_addr_reg   <= drv_addr_next;
                drv_data_reg   <= drv_data_next;
                grant_reg      <= grant_next;
            end
            if (item_ready)
            begin
                res_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    `CBCS_ASSERT_SAME(a_grant_only_idle, clk, rst_n,
        step && !grant_reg && grant_next, phase_reg == cbcs_pkg::PH_IDLE)
    `CBCS_ASSERT_SAME(a_mem_op_at_start, clk, rst_n,
        step && tick_mem_op != cbcs_pkg::MEM_NONE,
        cur == cbcs_pkg::PH_R2 || cur == cbcs_pkg::PH_MR2 ||
        cur == cbcs_pkg::PH_W2 || cur == cbcs_pkg::PH_MW2)
    `CBCS_ASSERT_NEXT(a_status_ends_cycle, clk, rst_n,
        step && tick_status != cbcs_pkg::STATUS_NONE, phase_reg == cbcs_pkg::PH_IDLE)
    `CBCS_ASSERT_SAME(a_addr_err_word_odd, clk, rst_n,
        step && tick_status != cbcs_pkg::STATUS_NONE &&
        tick_status != cbcs_pkg::STATUS_DONE,
        !held_byte_next && held_addr_next[0])

endmodule
